// ===== rtl/tdts_pkg.sv =====
// Shared types and constants of the tick-driven task scheduler.
// No dependencies; every other file of the block imports this package.
package tdts_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned IN_SLOT_W  = 3;
  localparam int unsigned OUT_SLOT_W = 3;
  localparam int unsigned IN_CNT_W   = 16;
  localparam int unsigned PRIO_W     = 16;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Opcodes of an input word.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd2;

  // Policy codes.
  localparam logic POLICY_SJF  = 1'b0;
  localparam logic POLICY_PRIO = 1'b1;

  // Galois right-shift LFSR taps, x^16+x^14+x^13+x^11+1.
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;
  localparam logic [LFSR_W-1:0] MASK_RESET = 16'h000F;

  // Saturated counter sum code meaning "two or more".
  localparam logic [1:0] SUM_MANY = 2'd2;

  // Write command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_NONE,
    CELL_LOAD,
    CELL_REFILL,
    CELL_DEC
  } cell_op_e;

  // Control word broadcast to the cells.
  typedef struct packed {
    cell_op_e op;
    logic     policy;
  } cell_ctl_t;

  // Status handed from one cell to the next during a scan.
  typedef struct packed {
    logic       found;
    logic       run_zero;
    logic [1:0] sum;
  } scan_flags_t;

endpackage

// ===== rtl/tdts_if.sv =====
// Handshake channels of the task scheduler: input words, result words and
// configuration writes. Depends on tdts_pkg for the field widths.

interface tdts_in_if import tdts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [IN_SLOT_W-1:0] slot_index;
  logic [IN_CNT_W-1:0]  slot_counter;
  logic [PRIO_W-1:0]    slot_priority;

  modport source (output valid, opcode, slot_index, slot_counter, slot_priority,
                  input ready);
  modport sink   (input valid, opcode, slot_index, slot_counter, slot_priority,
                  output ready);
endinterface

interface tdts_out_if import tdts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_SLOT_W-1:0] running_task;
  logic                  switched;
  logic                  refilled;

  modport source (output valid, running_task, switched, refilled, input ready);
  modport sink   (input valid, running_task, switched, refilled, output ready);
endinterface

interface tdts_cfg_if import tdts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tdts_cell.sv =====
// One task slot of the scheduler chain: its counter and priority, and one
// registered step of the sum and pick scan. Depends on tdts_pkg.
module tdts_cell import tdts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 8,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned CELL_ID    = 1,
  localparam int unsigned SLOT_W    = $clog2(TASK_SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Broadcast write command and running slot.
  input  cell_ctl_t             ctl_i,
  input  logic [SLOT_W-1:0]     wr_slot_i,
  input  logic [COUNT_BITS-1:0] wr_cnt_i,
  input  logic [PRIO_W-1:0]     wr_prio_i,
  input  logic [SLOT_W-1:0]     run_slot_i,
  // Scan data from the previous cell.
  input  scan_flags_t           flags_i,
  input  logic [SLOT_W-1:0]     best_slot_i,
  input  logic [COUNT_BITS-1:0] best_cnt_i,
  input  logic [PRIO_W-1:0]     best_prio_i,
  // Scan data to the next cell.
  output scan_flags_t           flags_o,
  output logic [SLOT_W-1:0]     best_slot_o,
  output logic [COUNT_BITS-1:0] best_cnt_o,
  output logic [PRIO_W-1:0]     best_prio_o
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_ID);

  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [PRIO_W-1:0]     prio_q, prio_d;
  scan_flags_t           flags_q, flags_d;
  logic [SLOT_W-1:0]     best_slot_q, best_slot_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;
  logic [PRIO_W-1:0]     best_prio_q, best_prio_d;

  logic       hit;
  logic       nz;
  logic       better;
  logic       take;
  logic [1:0] own_sum;
  logic [2:0] sum_w;

  assign hit = (wr_slot_i == MY_SLOT);

  // Slot state update from the broadcast command.
  always_comb begin
    cnt_d  = cnt_q;
    prio_d = prio_q;
    case (ctl_i.op)
      CELL_LOAD: begin
        if (hit) begin
          cnt_d  = wr_cnt_i;
          prio_d = wr_prio_i;
        end
      end
      CELL_REFILL: begin
        if (hit) begin
          cnt_d = wr_cnt_i;
        end
      end
      CELL_DEC: begin
        if (hit && (cnt_q != '0)) begin
          cnt_d = cnt_q - COUNT_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  // Scan step: this slot replaces the best so far only when strictly better,
  // so the lowest slot wins a tie.
  assign nz     = (cnt_q != '0);
  assign better = (ctl_i.policy == POLICY_PRIO) ? (prio_q > best_prio_i)
                                                : (cnt_q < best_cnt_i);
  assign take   = nz && (!flags_i.found || better);

  // Counter sum saturated at two, which is all the refill test needs.
  assign own_sum = !nz ? 2'd0 : ((cnt_q == COUNT_BITS'(1)) ? 2'd1 : SUM_MANY);
  assign sum_w   = {1'b0, flags_i.sum} + {1'b0, own_sum};

  always_comb begin
    flags_d.found    = flags_i.found || nz;
    flags_d.run_zero = flags_i.run_zero || ((run_slot_i == MY_SLOT) && !nz);
    flags_d.sum      = (sum_w >= 3'd2) ? SUM_MANY : sum_w[1:0];
    best_slot_d      = take ? MY_SLOT : best_slot_i;
    best_cnt_d       = take ? cnt_q   : best_cnt_i;
    best_prio_d      = take ? prio_q  : best_prio_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      prio_q  <= '0;
      flags_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      prio_q  <= prio_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_slot_q <= best_slot_d;
    best_cnt_q  <= best_cnt_d;
    best_prio_q <= best_prio_d;
  end

  assign flags_o     = flags_q;
  assign best_slot_o = best_slot_q;
  assign best_cnt_o  = best_cnt_q;
  assign best_prio_o = best_prio_q;

endmodule

// ===== rtl/tick_driven_task_scheduler_core.sv =====
// Load word: result registered in the cycle after acceptance; loads go one per cycle
// while the output is not stalled. Tick word: sum scan, then refill and pick scan when
// the counters are refilled, then decrement of the running counter, final pick scan
// and result; each scan waits for the cell chain, and the refill writes one slot per cycle.
// Reset: all counters and priorities zero, idle slot running, LFSR 1, mask 15, SJF.
// Depends on tdts_pkg, tdts_if and tdts_cell.
module tick_driven_task_scheduler_core import tdts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdts_in_if.sink   in_i,
  tdts_out_if.source out_o,
  tdts_cfg_if.sink  cfg_i
);

  localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
  localparam int unsigned RW     = (COUNT_BITS > 17) ? COUNT_BITS : 17;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
  localparam logic [RW-1:0]     CNT_LIMIT = RW'((64'd1 << COUNT_BITS) - 64'd1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_REFILL = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_STEP   = 3'd4;
  localparam logic [2:0] ST_FINAL  = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] step_q, step_d;
  logic [SLOT_W-1:0] running_q, running_d;
  logic [SLOT_W-1:0] before_q, before_d;
  logic              refilled_q, refilled_d;
  logic              policy_q, policy_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [LFSR_W-1:0] mask_q, mask_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_SLOT_W-1:0] out_run_q, out_run_d;
  logic                  out_sw_q, out_sw_d;
  logic                  out_rf_q, out_rf_d;

  logic in_fire;
  logic cfg_fire;
  logic scan_done;
  logic load_hit;

  // Broadcast command to the chain.
  cell_ctl_t             ctl;
  logic [SLOT_W-1:0]     wr_slot;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [PRIO_W-1:0]     wr_prio;

  // Refill value generation.
  logic [LFSR_W-1:0] lfsr_nxt;
  logic [16:0]       rnd_sum;
  logic [RW-1:0]     rnd_ext;
  logic [COUNT_BITS-1:0] refill_val;

  // Chain links; entry 0 is the empty start of the scan.
  scan_flags_t           ch_flags [TASK_SLOTS];
  logic [SLOT_W-1:0]     ch_slot  [TASK_SLOTS];
  logic [COUNT_BITS-1:0] ch_cnt   [TASK_SLOTS];
  logic [PRIO_W-1:0]     ch_prio  [TASK_SLOTS];

  assign ch_flags[0] = '0;
  assign ch_slot[0]  = '0;
  assign ch_cnt[0]   = '0;
  assign ch_prio[0]  = '0;

  // Row of slot cells, one per task slot other than the idle slot.
  for (genvar k = 1; k < TASK_SLOTS; k++) begin : g_cell
    tdts_cell #(
      .TASK_SLOTS (TASK_SLOTS),
      .COUNT_BITS (COUNT_BITS),
      .CELL_ID    (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .wr_slot_i   (wr_slot),
      .wr_cnt_i    (wr_cnt),
      .wr_prio_i   (wr_prio),
      .run_slot_i  (running_q),
      .flags_i     (ch_flags[k-1]),
      .best_slot_i (ch_slot[k-1]),
      .best_cnt_i  (ch_cnt[k-1]),
      .best_prio_i (ch_prio[k-1]),
      .flags_o     (ch_flags[k]),
      .best_slot_o (ch_slot[k]),
      .best_cnt_o  (ch_cnt[k]),
      .best_prio_o (ch_prio[k])
    );
  end

  // Handshakes.
  assign in_i.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  assign out_o.valid        = out_valid_q;
  assign out_o.running_task = out_run_q;
  assign out_o.switched     = out_sw_q;
  assign out_o.refilled     = out_rf_q;

  // The chain output reflects the state once the step counter reaches the last slot.
  assign scan_done = (step_q == LAST_SLOT);
  assign load_hit  = (in_i.slot_index != '0) && (32'(in_i.slot_index) < TASK_SLOTS);

  // Next random value and the saturated refill count.
  assign lfsr_nxt   = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
  assign rnd_sum    = {1'b0, lfsr_nxt & mask_q} + 17'd1;
  assign rnd_ext    = RW'(rnd_sum);
  assign refill_val = (rnd_ext > CNT_LIMIT) ? COUNT_BITS'(CNT_LIMIT) : COUNT_BITS'(rnd_ext);

  // Configuration registers; a seed of zero loads as one.
  always_comb begin
    policy_d = policy_q;
    mask_d   = mask_q;
    lfsr_d   = (state_q == ST_REFILL) ? lfsr_nxt : lfsr_q;
    if (cfg_fire) begin
      case (cfg_i.index)
        CFG_POLICY: policy_d = cfg_i.data[0];
        CFG_SEED:   lfsr_d   = (cfg_i.data == '0) ? LFSR_RESET : cfg_i.data;
        CFG_MASK:   mask_d   = cfg_i.data;
        default: ;
      endcase
    end
  end

  // Sequencer for load and tick words.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    running_d   = running_q;
    before_d    = before_q;
    refilled_d  = refilled_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_run_d   = out_run_q;
    out_sw_d    = out_sw_q;
    out_rf_d    = out_rf_q;
    ctl.op      = CELL_NONE;
    ctl.policy  = policy_q;
    wr_slot     = '0;
    wr_cnt      = '0;
    wr_prio     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_LOAD) begin
            if (load_hit) begin
              ctl.op  = CELL_LOAD;
              wr_slot = SLOT_W'(in_i.slot_index);
              wr_cnt  = COUNT_BITS'(in_i.slot_counter);
              wr_prio = in_i.slot_priority;
            end
            out_valid_d = 1'b1;
            out_run_d   = OUT_SLOT_W'(running_q);
            out_sw_d    = 1'b0;
            out_rf_d    = 1'b0;
          end else begin
            before_d   = running_q;
            refilled_d = 1'b0;
            step_d     = '0;
            state_d    = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (scan_done) begin
          if (ch_flags[TASK_SLOTS-1].sum != SUM_MANY) begin
            refilled_d = 1'b1;
            step_d     = SLOT_W'(1);
            state_d    = ST_REFILL;
          end else begin
            state_d = ST_STEP;
          end
        end else begin
          step_d = step_q + SLOT_W'(1);
        end
      end
      ST_REFILL: begin
        // One slot per cycle, in slot order, LFSR advancing each time.
        ctl.op  = CELL_REFILL;
        wr_slot = step_q;
        wr_cnt  = refill_val;
        if (step_q == LAST_SLOT) begin
          step_d  = '0;
          state_d = ST_PICK;
        end else begin
          step_d = step_q + SLOT_W'(1);
        end
      end
      ST_PICK: begin
        if (scan_done) begin
          if (ch_flags[TASK_SLOTS-1].found) begin
            running_d = ch_slot[TASK_SLOTS-1];
          end
          state_d = ST_STEP;
        end else begin
          step_d = step_q + SLOT_W'(1);
        end
      end
      ST_STEP: begin
        if (running_q != '0) begin
          ctl.op  = CELL_DEC;
          wr_slot = running_q;
        end
        step_d  = '0;
        state_d = ST_FINAL;
      end
      ST_FINAL: begin
        // Pick when idle runs or the running counter has reached zero.
        if (scan_done) begin
          if (ch_flags[TASK_SLOTS-1].found &&
              ((running_q == '0) || ch_flags[TASK_SLOTS-1].run_zero)) begin
            running_d = ch_slot[TASK_SLOTS-1];
          end
          state_d = ST_OUT;
        end else begin
          step_d = step_q + SLOT_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_run_d   = OUT_SLOT_W'(running_q);
          out_sw_d    = (running_q != before_q);
          out_rf_d    = refilled_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      running_q   <= '0;
      before_q    <= '0;
      refilled_q  <= 1'b0;
      policy_q    <= POLICY_SJF;
      lfsr_q      <= LFSR_RESET;
      mask_q      <= MASK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      running_q   <= running_d;
      before_q    <= before_d;
      refilled_q  <= refilled_d;
      policy_q    <= policy_d;
      lfsr_q      <= lfsr_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_run_q <= out_run_d;
    out_sw_q  <= out_sw_d;
    out_rf_q  <= out_rf_d;
  end

  // A tick word always starts a fresh sum scan.
  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.opcode == OP_TICK) |=> (state_q == ST_SUM) && (step_q == '0))
    else $error("tick accepted without starting a sum scan");

  // The refill never writes the idle slot.
  a_refill_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REFILL) |-> (step_q != '0))
    else $error("refill addressed the idle slot");

  // After a refill every counter is non-zero, so the pick must find a task.
  a_refill_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) && scan_done |-> ch_flags[TASK_SLOTS-1].found)
    else $error("pick after refill found no task");

  // The running task changes only at the end of a pick scan.
  a_running_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running_q != $past(running_q)) |->
      (($past(state_q) == ST_PICK) || ($past(state_q) == ST_FINAL)))
    else $error("running task changed outside a pick");

endmodule
